// ----- hdl/gbir_pkg.sv -----
// ----------------------------------------------------------------------------
// gbir_pkg
// Shared types, constants and codes of the grid boundary index resolver.
// ----------------------------------------------------------------------------
package gbir_pkg;

   localparam int MAX_DIMS       = 4;
   localparam int COORD_BITS     = 32;
   localparam int SIZE_BITS      = 16;
   // divisor and remainder width: the reflect period 2*size-2 needs one bit more
   localparam int DIV_BITS       = SIZE_BITS + 1;
   localparam int DIM_BITS       = 2;
   localparam int DIM_COUNT_BITS = 3;
   localparam int MODE_BITS      = 3;
   localparam int MODES_REG_BITS = 12;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = (SIZE_BITS > MODES_REG_BITS) ? SIZE_BITS : MODES_REG_BITS;

   // register indexes of the csr port
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DIM_COUNT      = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SIZE_DIM0      = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BOUNDARY_MODES = 3'd5;

   // boundary mode codes
   localparam logic [MODE_BITS-1:0] MODE_PERIODIC  = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_REFLECT   = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_DIRICHLET = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_ABSORB    = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_NEUMANN   = 3'd4;

   // how the back end forms the result
   typedef enum logic [1:0] {
      KIND_FIXED,
      KIND_PERIODIC,
      KIND_REFLECT
   } kind_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] coordinate;
      logic [DIM_BITS-1:0]          dim_index;
   } req_type;

   typedef struct packed {
      logic [SIZE_BITS-1:0] cell_index;
      logic                 forced_zero;
   } rsp_type;

   // data carried along the remainder chain
   typedef struct packed {
      logic [DIV_BITS-1:0]   rem;
      logic [COORD_BITS-1:0] dividend;
      logic [DIV_BITS-1:0]   divisor;
      logic [SIZE_BITS-1:0]  size;
      logic                  neg;
      kind_type              kind;
      logic [SIZE_BITS-1:0]  fixed;
      logic                  forced;
   } stage_type;

endpackage

// ----- hdl/gbir_front.sv -----
// ----------------------------------------------------------------------------
// gbir_front
// Decode stage: looks up size and mode of the dimension, settles every case
// that needs no remainder and sets up the remainder chain for the others.
// ----------------------------------------------------------------------------
module gbir_front #(
   parameter int MAX_DIMS = gbir_pkg::MAX_DIMS
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic [gbir_pkg::DIM_COUNT_BITS-1:0]             dim_count,
   input  logic [gbir_pkg::SIZE_BITS-1:0]                  size_regs [MAX_DIMS],
   input  logic [gbir_pkg::MODE_BITS*MAX_DIMS-1:0]         modes,
   input  logic                                            in_valid,
   output logic                                            in_ready,
   input  gbir_pkg::req_type                               in_data,
   output logic                                            out_valid,
   input  logic                                            out_ready,
   output gbir_pkg::stage_type                             out_data
);

   localparam int CB  = gbir_pkg::COORD_BITS;
   localparam int SB  = gbir_pkg::SIZE_BITS;
   localparam int DB  = gbir_pkg::DIV_BITS;
   localparam int CMP = (CB > DB) ? CB : DB;

   logic                            valid_ff, valid_in;
   gbir_pkg::stage_type             data_ff, data_in;
   logic                            found;
   logic [SB-1:0]                   size_sel;
   logic [gbir_pkg::MODE_BITS-1:0]  mode_sel;
   logic [SB-1:0]                   size_eff;
   logic [DB-1:0]                   period;
   logic [CB-1:0]                   coord_u;
   logic [CB-1:0]                   mag;
   logic                            neg;
   logic                            dim_ok;
   logic                            in_range;

   always_comb begin
      found    = 1'b0;
      size_sel = '0;
      mode_sel = '0;
      for (int i = 0; i < MAX_DIMS; i++) begin
         if (in_data.dim_index == gbir_pkg::DIM_BITS'(i)) begin
            found    = 1'b1;
            size_sel = size_regs[i];
            mode_sel = modes[gbir_pkg::MODE_BITS*i +: gbir_pkg::MODE_BITS];
         end
      end
   end

   always_comb begin
      coord_u  = in_data.coordinate;
      neg      = coord_u[CB-1];
      mag      = neg ? (~coord_u + CB'(1)) : coord_u;
      size_eff = (size_sel == '0) ? SB'(1) : size_sel;
      period   = (DB'(size_eff) << 1) - DB'(2);
      dim_ok   = found && (gbir_pkg::DIM_COUNT_BITS'(in_data.dim_index) < dim_count);
      in_range = !neg && (CMP'(mag) < CMP'(size_eff));

      data_in.rem      = '0;
      data_in.dividend = mag;
      data_in.divisor  = DB'(1);
      data_in.size     = size_eff;
      data_in.neg      = neg;
      data_in.kind     = gbir_pkg::KIND_FIXED;
      data_in.fixed    = '0;
      data_in.forced   = 1'b0;

      if (!dim_ok) begin
         data_in.forced = 1'b1;
      end else if (in_range) begin
         data_in.fixed = SB'(mag);
      end else begin
         case (mode_sel)
            gbir_pkg::MODE_PERIODIC: begin
               data_in.kind    = gbir_pkg::KIND_PERIODIC;
               data_in.divisor = DB'(size_eff);
            end
            gbir_pkg::MODE_REFLECT: begin
               // size one has no period, result stays zero
               if (size_eff != SB'(1)) begin
                  data_in.kind    = gbir_pkg::KIND_REFLECT;
                  data_in.divisor = period;
               end
            end
            gbir_pkg::MODE_NEUMANN: begin
               data_in.fixed = neg ? '0 : (size_eff - SB'(1));
            end
            default: begin
               data_in.forced = 1'b1;
            end
         endcase
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ----- hdl/gbir_cell.sv -----
// ----------------------------------------------------------------------------
// gbir_cell
// One step of the remainder chain: shifts in the next dividend bit and
// subtracts the divisor when it fits, then hands the transaction on.
// ----------------------------------------------------------------------------
module gbir_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  gbir_pkg::stage_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output gbir_pkg::stage_type out_data
);

   localparam int CB = gbir_pkg::COORD_BITS;
   localparam int DB = gbir_pkg::DIV_BITS;

   logic                valid_ff, valid_in;
   gbir_pkg::stage_type data_ff, data_in;
   logic [DB:0]         partial;
   logic [DB:0]         diff;

   always_comb begin
      partial          = {in_data.rem, in_data.dividend[CB-1]};
      diff             = partial - {1'b0, in_data.divisor};
      data_in          = in_data;
      data_in.dividend = in_data.dividend << 1;
      // remainder stays below the divisor, so one subtract is enough
      if (partial >= {1'b0, in_data.divisor}) begin
         data_in.rem = diff[DB-1:0];
      end else begin
         data_in.rem = partial[DB-1:0];
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ----- hdl/gbir_back.sv -----
// ----------------------------------------------------------------------------
// gbir_back
// Result stage: turns the magnitude remainder into the positive remainder,
// folds it for reflecting mode and holds the result transaction.
// ----------------------------------------------------------------------------
module gbir_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  gbir_pkg::stage_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output gbir_pkg::rsp_type   out_data
);

   localparam int SB = gbir_pkg::SIZE_BITS;
   localparam int DB = gbir_pkg::DIV_BITS;

   logic              valid_ff, valid_in;
   gbir_pkg::rsp_type data_ff, data_in;
   logic [DB-1:0]     pos_rem;
   logic [DB-1:0]     folded;

   always_comb begin
      // negative coordinate: remainder of the magnitude counts down from the divisor
      if (in_data.neg && (in_data.rem != '0)) begin
         pos_rem = in_data.divisor - in_data.rem;
      end else begin
         pos_rem = in_data.rem;
      end
      if ((in_data.kind == gbir_pkg::KIND_REFLECT) && (pos_rem >= DB'(in_data.size))) begin
         folded = in_data.divisor - pos_rem;
      end else begin
         folded = pos_rem;
      end
      if (in_data.kind == gbir_pkg::KIND_FIXED) begin
         data_in.cell_index = in_data.fixed;
      end else begin
         data_in.cell_index = SB'(folded);
      end
      data_in.forced_zero = in_data.forced;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ----- hdl/grid_boundary_index_resolve.sv -----
// ----------------------------------------------------------------------------
// grid_boundary_index_resolve
// Resolves a signed grid coordinate to a cell index by the boundary mode of
// its dimension.
// ----------------------------------------------------------------------------
// Takes one coordinate transaction per clock while the result side keeps
// ready high and returns one result per transaction, in order, through
// one decode stage, a chain of 32 remainder cells (one coordinate bit per
// cell, so the chain length follows the coordinate width) and one result
// stage. Every stage holds its own valid bit, so a stall on the result side
// lets empty stages fill before the request side sees ready drop. Csr writes
// are taken in any cycle and must only be issued while no transaction is in
// flight.
module grid_boundary_index_resolve #(
   parameter int MAX_DIMS = gbir_pkg::MAX_DIMS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  gbir_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output gbir_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [gbir_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [gbir_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   localparam int NUM_CELLS = gbir_pkg::COORD_BITS;
   localparam int SB        = gbir_pkg::SIZE_BITS;
   localparam int MB        = gbir_pkg::MODE_BITS * MAX_DIMS;

   logic [gbir_pkg::DIM_COUNT_BITS-1:0] dim_count_ff, dim_count_in;
   logic [SB-1:0]                       size_ff [MAX_DIMS];
   logic [SB-1:0]                       size_in [MAX_DIMS];
   logic [MB-1:0]                       modes_ff, modes_in;
   logic                                csr_write;

   gbir_pkg::stage_type chain_data  [NUM_CELLS+1];
   logic                chain_valid [NUM_CELLS+1];
   logic                chain_ready [NUM_CELLS+1];

   // csr registers
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      dim_count_in = dim_count_ff;
      modes_in     = modes_ff;
      for (int i = 0; i < MAX_DIMS; i++) begin
         size_in[i] = size_ff[i];
         if (csr_write &&
             (csr_index == gbir_pkg::CSR_INDEX_BITS'(32'(gbir_pkg::CSR_SIZE_DIM0) + i))) begin
            size_in[i] = csr_data[SB-1:0];
         end
      end
      if (csr_write && (csr_index == gbir_pkg::CSR_DIM_COUNT)) begin
         dim_count_in = csr_data[gbir_pkg::DIM_COUNT_BITS-1:0];
      end
      if (csr_write && (csr_index == gbir_pkg::CSR_BOUNDARY_MODES)) begin
         modes_in = csr_data[MB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_count_ff <= '0;
         modes_ff     <= '0;
         for (int i = 0; i < MAX_DIMS; i++) begin
            size_ff[i] <= SB'(1);
         end
      end else begin
         dim_count_ff <= dim_count_in;
         modes_ff     <= modes_in;
         for (int i = 0; i < MAX_DIMS; i++) begin
            size_ff[i] <= size_in[i];
         end
      end
   end

   gbir_front #(
      .MAX_DIMS (MAX_DIMS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .dim_count (dim_count_ff),
      .size_regs (size_ff),
      .modes     (modes_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_data  (chain_data[0])
   );

   // remainder chain, most significant coordinate bit first
   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      gbir_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[g]),
         .in_ready  (chain_ready[g]),
         .in_data   (chain_data[g]),
         .out_valid (chain_valid[g+1]),
         .out_ready (chain_ready[g+1]),
         .out_data  (chain_data[g+1])
      );
   end

   gbir_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[NUM_CELLS]),
      .in_ready  (chain_ready[NUM_CELLS]),
      .in_data   (chain_data[NUM_CELLS]),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the grid boundary index resolver.
// ----------------------------------------------------------------------------
// Directed transactions cover the coordinate extremes and every boundary mode.
// They also cover absent dimensions, a zero size register and reflection with
// a size of one. Random phases follow, each with its own grid setting. An
// in-bench resolver predicts every result, and results are checked in order.
// In some random phases the sender works in bursts; in some the receiver stalls at random.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD     = 6;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 204;
   localparam int SETTLE_CYCLES   = 40;
   localparam int STALL_LIMIT     = 2000;

   // mode codes the block does not define; they must force a zero
   localparam logic [gbir_pkg::MODE_BITS-1:0] MODE_SPARE     = 3'd5;
   localparam logic [gbir_pkg::MODE_BITS-1:0] MODE_SPARE_TOP = 3'd7;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   gbir_pkg::req_type req_data;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   gbir_pkg::rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [gbir_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [gbir_pkg::CSR_DATA_BITS-1:0] csr_data;

   // bench copy of the grid registers
   logic [gbir_pkg::DIM_COUNT_BITS-1:0] dims_used;
   logic [gbir_pkg::SIZE_BITS-1:0] cell_count [gbir_pkg::MAX_DIMS];
   logic [gbir_pkg::MODES_REG_BITS-1:0] mode_word;

   gbir_pkg::rsp_type resolved_q [$];
   int error_count = 0;
   int results_seen = 0;
   int forced_seen = 0;
   int grid_settings = 0;
   int quiet_cycles = 0;
   int burst_left = 0;
   int stall_left = 0;
   bit req_held = 1'b0;
   bit sender_idle_on = 1'b0;
   bit rsp_stall_on = 1'b0;

   grid_boundary_index_resolve dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   function automatic gbir_pkg::rsp_type resolve_cell(gbir_pkg::req_type r);
      gbir_pkg::rsp_type res;
      longint c;
      longint sz;
      longint period;
      longint rem;
      int d;
      logic [gbir_pkg::MODE_BITS-1:0] mode;
      c = longint'(r.coordinate);
      d = int'(r.dim_index);
      rem = 0;
      res.forced_zero = 1'b0;
      if (d >= int'(dims_used) || d >= gbir_pkg::MAX_DIMS) begin
         res.forced_zero = 1'b1;
      end else begin
         sz = longint'(cell_count[d]);
         if (sz < 1) sz = 1;
         mode = mode_word[gbir_pkg::MODE_BITS*d +: gbir_pkg::MODE_BITS];
         if (c >= 0 && c < sz) begin
            rem = c;
         end else begin
            case (mode)
               gbir_pkg::MODE_PERIODIC: begin
                  rem = c % sz;
                  if (rem < 0) rem += sz;
               end
               gbir_pkg::MODE_REFLECT: begin
                  if (sz > 1) begin
                     period = 2 * sz - 2;
                     rem = c % period;
                     if (rem < 0) rem += period;
                     if (rem >= sz) rem = period - rem;
                  end
               end
               gbir_pkg::MODE_NEUMANN: rem = (c < 0) ? 0 : sz - 1;
               default: res.forced_zero = 1'b1;
            endcase
         end
      end
      res.cell_index = rem[gbir_pkg::SIZE_BITS-1:0];
      return res;
   endfunction

   // all drive tasks start and end on a falling edge
   task automatic send_coord(input logic [gbir_pkg::COORD_BITS-1:0] coord,
                             input logic [gbir_pkg::DIM_BITS-1:0] dim);
      gbir_pkg::req_type r;
      int gap;
      r.coordinate = coord;
      r.dim_index = dim;
      req_valid <= 1'b1;
      req_data <= r;
      req_held = 1'b1;
      do @(posedge clock); while (!req_ready);
      resolved_q.insert(resolved_q.size(), resolve_cell(r));
      @(negedge clock);
      if (sender_idle_on) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 12);
            if (gap != 0) begin
               req_valid <= 1'b0;
               req_held = 1'b0;
               repeat (gap) @(negedge clock);
            end
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic sender_stop();
      if (req_held) begin
         req_valid <= 1'b0;
         req_held = 1'b0;
      end
   endtask

   task automatic drain_results();
      while (resolved_q.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [gbir_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [gbir_pkg::CSR_DATA_BITS-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == gbir_pkg::CSR_DIM_COUNT)
         dims_used = val[gbir_pkg::DIM_COUNT_BITS-1:0];
      else if (idx == gbir_pkg::CSR_BOUNDARY_MODES)
         mode_word = val[gbir_pkg::MODES_REG_BITS-1:0];
      else if (idx >= gbir_pkg::CSR_SIZE_DIM0 &&
               idx < gbir_pkg::CSR_SIZE_DIM0 + gbir_pkg::MAX_DIMS)
         cell_count[idx - gbir_pkg::CSR_SIZE_DIM0] = val[gbir_pkg::SIZE_BITS-1:0];
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // registers change only with nothing in flight
   task automatic write_grid(input logic [gbir_pkg::DIM_COUNT_BITS-1:0] count,
                             input logic [gbir_pkg::SIZE_BITS-1:0] s0,
                             input logic [gbir_pkg::SIZE_BITS-1:0] s1,
                             input logic [gbir_pkg::SIZE_BITS-1:0] s2,
                             input logic [gbir_pkg::SIZE_BITS-1:0] s3,
                             input logic [gbir_pkg::MODES_REG_BITS-1:0] modes);
      sender_stop();
      drain_results();
      write_reg(gbir_pkg::CSR_DIM_COUNT, gbir_pkg::CSR_DATA_BITS'(count));
      write_reg(gbir_pkg::CSR_SIZE_DIM0, s0);
      write_reg(gbir_pkg::CSR_INDEX_BITS'(gbir_pkg::CSR_SIZE_DIM0 + 1), s1);
      write_reg(gbir_pkg::CSR_INDEX_BITS'(gbir_pkg::CSR_SIZE_DIM0 + 2), s2);
      write_reg(gbir_pkg::CSR_INDEX_BITS'(gbir_pkg::CSR_SIZE_DIM0 + 3), s3);
      write_reg(gbir_pkg::CSR_BOUNDARY_MODES, gbir_pkg::CSR_DATA_BITS'(modes));
      grid_settings++;
   endtask

   function automatic logic [gbir_pkg::SIZE_BITS-1:0] pick_size();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return gbir_pkg::SIZE_BITS'(1);
         2: return '1;
         3: return gbir_pkg::SIZE_BITS'($urandom);
         4: return gbir_pkg::SIZE_BITS'(2);
         default: return gbir_pkg::SIZE_BITS'($urandom_range(3, 64));
      endcase
   endfunction

   // mostly near the valid range so every fold and wrap gets exercised
   function automatic logic [gbir_pkg::COORD_BITS-1:0] pick_coord(input longint sz);
      longint span;
      span = sz * 3;
      case ($urandom_range(0, 7))
         0, 1: return $urandom;
         2: return gbir_pkg::COORD_BITS'($urandom_range(0, sz - 1));
         3: return gbir_pkg::COORD_BITS'(sz + $urandom_range(0, span));
         4: return gbir_pkg::COORD_BITS'(-longint'($urandom_range(1, span)));
         5: begin
            case ($urandom_range(0, 3))
               0: return 32'h7fff_ffff;
               1: return 32'h8000_0000;
               2: return '1;
               default: return gbir_pkg::COORD_BITS'(sz);
            endcase
         end
         default: return gbir_pkg::COORD_BITS'(longint'($urandom_range(0, 2 * span)) - span);
      endcase
   endfunction

   task automatic test_after_reset();
      // no dimension is in use after reset
      send_coord(32'd0, 2'd0);
      send_coord(32'h7fff_ffff, 2'd3);
   endtask

   task automatic test_wrap_and_fold();
      write_grid(3'd4, 16'hffff, 16'hffff, 16'd1, 16'd5,
                 {gbir_pkg::MODE_NEUMANN, gbir_pkg::MODE_REFLECT,
                  gbir_pkg::MODE_REFLECT, gbir_pkg::MODE_PERIODIC});
      send_coord(32'h7fff_ffff, 2'd0);
      send_coord(32'h8000_0000, 2'd0);
      send_coord(32'hffff_ffff, 2'd0);
      send_coord(32'd65534, 2'd0);
      send_coord(32'd65535, 2'd1);
      send_coord(32'hffff_ffff, 2'd1);
      send_coord(32'h8000_0000, 2'd1);
      // reflection with a single cell
      send_coord(32'd5, 2'd2);
      send_coord(-32'sd3, 2'd2);
      send_coord(32'h7fff_ffff, 2'd3);
      send_coord(32'h8000_0000, 2'd3);
      send_coord(32'd2, 2'd3);
   endtask

   task automatic test_forced_zero();
      // dimension three has a zero size register
      write_grid(3'd4, 16'd10, 16'd10, 16'd10, 16'd0,
                 {gbir_pkg::MODE_PERIODIC, MODE_SPARE,
                  gbir_pkg::MODE_ABSORB, gbir_pkg::MODE_DIRICHLET});
      send_coord(32'd4, 2'd0);
      send_coord(32'd10, 2'd0);
      send_coord(-32'sd1, 2'd1);
      send_coord(32'd9, 2'd1);
      send_coord(-32'sd5, 2'd2);
      send_coord(32'd3, 2'd2);
      send_coord(32'h8000_0000, 2'd3);
      send_coord(32'd12345, 2'd3);
   endtask

   task automatic test_absent_dims();
      write_grid(3'd2, 16'd3, 16'd8, 16'd8, 16'd8,
                 {gbir_pkg::MODE_PERIODIC, gbir_pkg::MODE_PERIODIC,
                  gbir_pkg::MODE_NEUMANN, MODE_SPARE_TOP});
      send_coord(32'd5, 2'd0);
      send_coord(32'd1, 2'd0);
      send_coord(32'd7, 2'd2);
      send_coord(-32'sd9, 2'd3);
   endtask

   task automatic test_random();
      logic [gbir_pkg::SIZE_BITS-1:0] sz [gbir_pkg::MAX_DIMS];
      logic [gbir_pkg::MODES_REG_BITS-1:0] modes;
      logic [gbir_pkg::DIM_COUNT_BITS-1:0] count;
      logic [gbir_pkg::DIM_BITS-1:0] d;
      int lanes;
      longint eff;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         for (int i = 0; i < gbir_pkg::MAX_DIMS; i++) begin
            if (phase == 0) sz[i] = '1;
            else if (phase == 1) sz[i] = gbir_pkg::SIZE_BITS'(1);
            else sz[i] = pick_size();
            if ($urandom_range(0, 7) == 0)
               modes[gbir_pkg::MODE_BITS*i +: gbir_pkg::MODE_BITS] =
                  gbir_pkg::MODE_BITS'($urandom_range(MODE_SPARE, MODE_SPARE_TOP));
            else
               modes[gbir_pkg::MODE_BITS*i +: gbir_pkg::MODE_BITS] =
                  gbir_pkg::MODE_BITS'($urandom_range(gbir_pkg::MODE_PERIODIC,
                                                      gbir_pkg::MODE_NEUMANN));
         end
         if (phase > 1 && $urandom_range(0, 3) == 0)
            count = gbir_pkg::DIM_COUNT_BITS'($urandom_range(0, 7));
         else
            count = gbir_pkg::DIM_COUNT_BITS'(gbir_pkg::MAX_DIMS);
         write_grid(count, sz[0], sz[1], sz[2], sz[3], modes);
         sender_idle_on = (phase % 3 != 0);
         rsp_stall_on = (phase % 2 == 1);
         lanes = (int'(count) < gbir_pkg::MAX_DIMS) ? int'(count) : gbir_pkg::MAX_DIMS;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (lanes != 0 && $urandom_range(0, 7) != 0)
               d = gbir_pkg::DIM_BITS'($urandom_range(0, lanes - 1));
            else
               d = gbir_pkg::DIM_BITS'($urandom_range(0, gbir_pkg::MAX_DIMS - 1));
            eff = (cell_count[d] == 0) ? 1 : longint'(cell_count[d]);
            send_coord(pick_coord(eff), d);
            // hold the sender until the pipeline has emptied
            if (phase == 3 && n == ITEMS_PER_PHASE / 2) begin
               sender_stop();
               drain_results();
            end
         end
      end
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!rsp_stall_on || $urandom_range(0, 4) != 0) begin
         rsp_ready <= 1'b1;
      end else begin
         stall_left = $urandom_range(0, 9);
         rsp_ready <= 1'b0;
      end
   end

   always @(posedge clock) begin : check_rsp
      gbir_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (resolved_q.size() == 0) begin
            $display("%0t: result with nothing pending, cell_index %0d forced_zero %0b",
                     $time, rsp_data.cell_index, rsp_data.forced_zero);
            error_count++;
         end else begin
            want = resolved_q.pop_front();
            results_seen++;
            if (want.forced_zero) forced_seen++;
            if (rsp_data.cell_index !== want.cell_index) begin
               $display("%0t: cell_index mismatch, expected %0d, actual %0d",
                        $time, want.cell_index, rsp_data.cell_index);
               error_count++;
            end
            if (rsp_data.forced_zero !== want.forced_zero) begin
               $display("%0t: forced_zero mismatch, expected %0b, actual %0b",
                        $time, want.forced_zero, rsp_data.forced_zero);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d results pending",
                     $time, STALL_LIMIT, resolved_q.size());
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      dims_used = '0;
      mode_word = '0;
      for (int i = 0; i < gbir_pkg::MAX_DIMS; i++) cell_count[i] = gbir_pkg::SIZE_BITS'(1);
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_after_reset();
      test_wrap_and_fold();
      test_forced_zero();
      test_absent_dims();
      test_random();

      sender_stop();
      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Checked %0d results, %0d of them forced zeros, over %0d grid settings",
               results_seen, forced_seen, grid_settings);
      $display("with all boundary modes, absent dimensions, and random gaps and stalls");
      if (error_count == 0 && resolved_q.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
